/* rtl/h27sf_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the hex27 shape function evaluator.
// No dependencies; imported by the front, queue, back and top level files.
package h27sf_pkg;

	localparam int COORD_W   = 16;
	localparam int FAC_W     = 33;
	localparam int RES_W     = 18;
	localparam int NODE_W    = 5;
	localparam int NODE_COUNT = 27;
	localparam int IN_W      = 48;
	localparam int OUT_W     = 80;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam int PROD1_W = 2 * FAC_W;
	localparam int P_W     = 34;
	localparam int PROD2_W = P_W + FAC_W;
	localparam int Q_W     = 25;

	localparam int SHIFT_P = 30;
	localparam int SHIFT_Q = 43;

	localparam logic [NODE_W-1:0] NODE_LAST = NODE_W'(NODE_COUNT - 1);
	localparam logic [1:0]        AXIS_LAST = 2'd2;

	typedef logic signed [FAC_W-1:0] fac_t;

	typedef struct packed {
		fac_t [2:0] val;
		fac_t [2:0] der;
	} axis_t;

	typedef struct packed {
		axis_t zeta;
		axis_t eta;
		axis_t xi;
	} fset_t;

endpackage

/* rtl/h27sf_front.sv */
`timescale 1ns / 1ps
// Front part: takes one point word, forms the 1-D Lagrange factors per axis.
// Depends on h27sf_pkg; feeds h27sf_fifo.
module h27sf_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [h27sf_pkg::IN_W-1:0] s_tdata,
	output logic                     push,
	output h27sf_pkg::fset_t         push_data,
	input  logic                     full
);
	import h27sf_pkg::*;

	localparam fac_t ONE_VAL  = fac_t'(64'sd536870912);
	localparam fac_t HALF_DER = fac_t'(64'sd8192);

	logic                      valid_s1;
	logic signed [COORD_W-1:0] xi_s1;
	logic signed [COORD_W-1:0] eta_s1;
	logic signed [COORD_W-1:0] zeta_s1;

	function automatic axis_t axis_factors(input logic signed [COORD_W-1:0] x);
		logic signed [2*COORD_W-1:0] sq32;
		fac_t  xe;
		fac_t  sq;
		fac_t  xh;
		axis_t f;
		sq32 = x * x;
		xe = FAC_W'(x);
		sq = FAC_W'(sq32);
		xh = xe <<< 14;
		f.val[0] = sq - xh;
		f.val[1] = ONE_VAL - (sq <<< 1);
		f.val[2] = sq + xh;
		f.der[0] = (xe - HALF_DER) <<< 15;
		f.der[1] = -(xe <<< 16);
		f.der[2] = (xe + HALF_DER) <<< 15;
		return f;
	endfunction

	assign s_tready = !valid_s1 || !full;
	assign push     = valid_s1 && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			xi_s1   <= s_tdata[15:0];
			eta_s1  <= s_tdata[31:16];
			zeta_s1 <= s_tdata[47:32];
		end
	end

	always_comb begin
		push_data.xi   = axis_factors(xi_s1);
		push_data.eta  = axis_factors(eta_s1);
		push_data.zeta = axis_factors(zeta_s1);
	end

endmodule

/* rtl/h27sf_fifo.sv */
`timescale 1ns / 1ps
// Short queue of factor sets between the front and back parts.
// Depends on h27sf_pkg.
module h27sf_fifo #(
	parameter int DEPTH = h27sf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  h27sf_pkg::fset_t push_data,
	output logic             full,
	input  logic             pop,
	output h27sf_pkg::fset_t head,
	output logic             head_valid
);
	import h27sf_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	fset_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* rtl/h27sf_back.sv */
`timescale 1ns / 1ps
// Back part: walks the 27 nodes of the head factor set, two multiply stages
// and a rounding/saturating output register. Depends on h27sf_pkg.
module h27sf_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  h27sf_pkg::fset_t            head,
	input  logic                        head_valid,
	output logic                        pop,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [h27sf_pkg::OUT_W-1:0] m_tdata,
	output logic                        m_tlast
);
	import h27sf_pkg::*;

	localparam logic signed [PROD1_W:0] RND_P = (PROD1_W + 1)'(1) <<< (SHIFT_P - 1);
	localparam logic signed [PROD2_W:0] RND_Q = (PROD2_W + 1)'(1) <<< (SHIFT_Q - 1);
	localparam logic signed [Q_W-1:0]   Q_MAX = Q_W'(131071);
	localparam logic signed [Q_W-1:0]   Q_MIN = -Q_W'(131072);

	logic              en;
	logic              issue;
	logic [1:0]        i_q;
	logic [1:0]        j_q;
	logic [1:0]        k_q;
	logic [NODE_W-1:0] node_q;

	fac_t vx_sel, dx_sel, vy_sel, dy_sel, vz_sel, dz_sel;

	logic                       valid_s1;
	logic signed [PROD1_W-1:0]  vv_s1, dv_s1, vd_s1;
	fac_t                       vz_s1, dz_s1;
	logic [NODE_W-1:0]          node_s1;

	logic signed [P_W-1:0]      p_vv, p_dv, p_vd;

	logic                       valid_s2;
	logic signed [PROD2_W-1:0]  val_s2, dxi_s2, deta_s2, dzeta_s2;
	logic [NODE_W-1:0]          node_s2;

	logic                       m_tvalid_q;
	logic [NODE_W-1:0]          node_out_q;
	logic [RES_W-1:0]           val_q, dxi_q, deta_q, dzeta_q;

	function automatic logic signed [P_W-1:0] round_p(input logic signed [PROD1_W-1:0] v);
		logic signed [PROD1_W:0] w;
		w = (PROD1_W + 1)'(v) + RND_P;
		return w[SHIFT_P+P_W-1:SHIFT_P];
	endfunction

	function automatic logic [RES_W-1:0] round_sat(input logic signed [PROD2_W-1:0] v);
		logic signed [PROD2_W:0] w;
		logic signed [Q_W-1:0]   q;
		w = (PROD2_W + 1)'(v) + RND_Q;
		q = w[SHIFT_Q+Q_W-1:SHIFT_Q];
		if (q > Q_MAX) begin
			q = Q_MAX;
		end else if (q < Q_MIN) begin
			q = Q_MIN;
		end
		return q[RES_W-1:0];
	endfunction

	assign en    = !m_tvalid_q || m_tready;
	assign issue = en && head_valid;
	assign pop   = issue && (node_q == NODE_LAST);

	always_comb begin
		vx_sel = head.xi.val[i_q];
		dx_sel = head.xi.der[i_q];
		vy_sel = head.eta.val[j_q];
		dy_sel = head.eta.der[j_q];
		vz_sel = head.zeta.val[k_q];
		dz_sel = head.zeta.der[k_q];
	end

	always_comb begin
		p_vv = round_p(vv_s1);
		p_dv = round_p(dv_s1);
		p_vd = round_p(vd_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q        <= '0;
			j_q        <= '0;
			k_q        <= '0;
			node_q     <= '0;
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (issue) begin
				if (node_q == NODE_LAST) begin
					node_q <= '0;
				end else begin
					node_q <= node_q + 1'b1;
				end
				if (i_q != AXIS_LAST) begin
					i_q <= i_q + 1'b1;
				end else begin
					i_q <= '0;
					if (j_q != AXIS_LAST) begin
						j_q <= j_q + 1'b1;
					end else begin
						j_q <= '0;
						k_q <= (k_q != AXIS_LAST) ? k_q + 1'b1 : 2'd0;
					end
				end
			end
			if (en) begin
				valid_s1   <= head_valid;
				valid_s2   <= valid_s1;
				m_tvalid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vv_s1    <= PROD1_W'(vx_sel) * PROD1_W'(vy_sel);
			dv_s1    <= PROD1_W'(dx_sel) * PROD1_W'(vy_sel);
			vd_s1    <= PROD1_W'(vx_sel) * PROD1_W'(dy_sel);
			vz_s1    <= vz_sel;
			dz_s1    <= dz_sel;
			node_s1  <= node_q;
			val_s2   <= PROD2_W'(p_vv) * PROD2_W'(vz_s1);
			dxi_s2   <= PROD2_W'(p_dv) * PROD2_W'(vz_s1);
			deta_s2  <= PROD2_W'(p_vd) * PROD2_W'(vz_s1);
			dzeta_s2 <= PROD2_W'(p_vv) * PROD2_W'(dz_s1);
			node_s2  <= node_s1;
			node_out_q <= node_s2;
			val_q    <= round_sat(val_s2);
			dxi_q    <= round_sat(dxi_s2);
			deta_q   <= round_sat(deta_s2);
			dzeta_q  <= round_sat(dzeta_s2);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = (node_out_q == NODE_LAST);
	assign m_tdata  = {3'b000, dzeta_q, deta_q, dxi_q, val_q, node_out_q};

	a_pop_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (node_q == '0) && (i_q == '0) && (j_q == '0) && (k_q == '0))
		else $error("node walk did not restart after the last node");

	a_axis_range: assert property (@(posedge clk) disable iff (!arst_n)
		(i_q <= AXIS_LAST) && (j_q <= AXIS_LAST) && (k_q <= AXIS_LAST))
		else $error("axis counter out of range");

	a_node_order: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) ##1 m_tvalid
		|-> node_out_q == $past(node_out_q) + 1'b1)
		else $error("node words out of order");

	a_node_matches: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> node_q == NODE_W'(i_q) + NODE_W'(3) * NODE_W'(j_q) + NODE_W'(9) * NODE_W'(k_q))
		else $error("node index disagrees with axis counters");

endmodule

/* rtl/hex27_shape_function_eval.sv */
`timescale 1ns / 1ps
// Top level of the hex27 triquadratic shape function evaluator.
// Depends on h27sf_pkg, h27sf_front, h27sf_fifo and h27sf_back.
//
// Usage:
//   The slave channel takes one point word per handshake: xi, eta, zeta, each
//   signed Q2.14. For every point the master channel gives 27 words, nodes
//   0..26 in order n = i + 3*j + 9*k, each with the node index, the shape value
//   and its three partial derivatives in signed Q4.14 (saturated); tlast
//   marks node 26.
//   The front stage forms the 1-D factors of a point and parks them in a
//   queue of QUEUE_DEPTH points; the back part walks the 27 nodes of the
//   queue head through two multiply stages and an output register.
//   A point passes the front register and the queue, then the two multiply
//   stages and the output register. One result word per cycle while m_tready
//   is high and the queue is not empty, set by the single node walker.
//   Points are taken while earlier ones are still being walked, until the
//   queue and the front stage are full.
//   When the receiver deasserts m_tready while m_tvalid is high, the back
//   part holds every stage; the front keeps filling the queue. Reset clears
//   all valid flags and counters; no word is in flight after reset.
module hex27_shape_function_eval #(
	parameter int QUEUE_DEPTH = h27sf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// coord_xi [15:0], coord_eta [31:16], coord_zeta [47:32]
	input  logic [h27sf_pkg::IN_W-1:0]   s_tdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// node_index [4:0], shape_value [22:5], deriv_xi [40:23],
	// deriv_eta [58:41], deriv_zeta [76:59], zero [79:77]
	output logic [h27sf_pkg::OUT_W-1:0]  m_tdata,
	output logic                         m_tlast
);
	import h27sf_pkg::*;

	logic  push;
	logic  full;
	logic  pop;
	logic  head_valid;
	fset_t push_data;
	fset_t head;

	h27sf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	h27sf_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.full       (full),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid)
	);

	h27sf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

endmodule
